/* hdl/bptc_pkg.sv */
// bptc_pkg: shared types and constants of the barometric compensation block.
// No dependencies; imported by every module of the block but bptc_fifo.
package bptc_pkg;

   typedef enum logic [1:0] {
      CSR_CAL_TEMP    = 2'd0,
      CSR_CAL_PRESS_A = 2'd1,
      CSR_CAL_PRESS_B = 2'd2,
      CSR_CAL_P9      = 2'd3
   } bptc_csr_type;

   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } bptc_cal_type;

   // front to back queue entry
   typedef struct packed {
      logic        [19:0] raw_pressure;
      logic signed [23:0] t_fine;
      logic signed [15:0] temp_centi;
   } bptc_qitem_type;

   // sideband carried through the divider
   typedef struct packed {
      logic signed [15:0] temp_centi;
      logic               neg;
      logic               zero;
   } bptc_dmeta_type;

   localparam int QITEM_W    = $bits(bptc_qitem_type);
   localparam int DIV_STAGES = 64;

   localparam logic signed [24:0] TFINE_OFFSET = 25'sd128000;
   localparam logic        [20:0] PRESS_BASE   = 21'd1048576;
   localparam logic        [11:0] DIV_SCALE    = 12'd3125;
   localparam logic        [63:0] P1_BIAS      = 64'h0000_8000_0000_0000;
   localparam logic signed [26:0] TEMP_ROUND   = 27'sd128;
   localparam logic signed [26:0] TEMP_MUL     = 27'sd5;

endpackage

/* hdl/bptc_if.sv */
// bptc_req_if / bptc_rsp_if: valid/ready channels of the compensation block.
// No dependencies.
interface bptc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   modport source(output valid, raw_temperature, raw_pressure, input ready);
   modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bptc_rsp_if;
   logic               valid;
   logic               ready;
   logic        [23:0] pressure_pa;
   logic               pressure_valid;
   logic signed [15:0] temperature_centi;
   modport source(output valid, pressure_pa, pressure_valid, temperature_centi,
                  input ready);
   modport sink(input valid, pressure_pa, pressure_valid, temperature_centi,
                output ready);
endinterface

/* hdl/baro_pressure_temp_compensation.sv */
// baro_pressure_temp_compensation: top level, calibration registers and wiring.
// Depends on bptc_pkg, bptc_if, bptc_front, bptc_fifo and bptc_back.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid/ready        raw_temperature[19:0], raw_pressure[19:0]
//   rsp_ch    out   valid/ready        pressure_pa[23:0], pressure_valid,
//                                      temperature_centi[15:0] signed
//   csr_*     in    csr_we             csr_index[1:0], csr_wdata[63:0]
//
// One request per cycle sustained while rsp_ch is not stalled; a request passes
// the front stages, the queue and the back stages around the 64-stage divider.
// Synchronous reset clears calibration to zero and empties all stages.
// A stalled response holds the whole back pipe; the queue then absorbs the
// front, which stalls req_ch once the queue fills.
module baro_pressure_temp_compensation import bptc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   bptc_req_if.sink    req_ch,
   bptc_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff;
   logic [63:0] cal_press_b_ff;
   logic [15:0] cal_p9_ff;
   bptc_cal_type cal;

   logic           push, full, avail, pop;
   bptc_qitem_type push_item, pop_item;
   logic [QITEM_W-1:0] q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_p9_ff      <= '0;
      end else if (csr_we) begin
         unique case (bptc_csr_type'(csr_index))
            CSR_CAL_TEMP:    cal_temp_ff    <= csr_wdata[47:0];
            CSR_CAL_PRESS_A: cal_press_a_ff <= csr_wdata;
            CSR_CAL_PRESS_B: cal_press_b_ff <= csr_wdata;
            CSR_CAL_P9:      cal_p9_ff      <= csr_wdata[15:0];
         endcase
      end
   end

   assign cal.t1 = cal_temp_ff[15:0];
   assign cal.t2 = cal_temp_ff[31:16];
   assign cal.t3 = cal_temp_ff[47:32];
   assign cal.p1 = cal_press_a_ff[15:0];
   assign cal.p2 = cal_press_a_ff[31:16];
   assign cal.p3 = cal_press_a_ff[47:32];
   assign cal.p4 = cal_press_a_ff[63:48];
   assign cal.p5 = cal_press_b_ff[15:0];
   assign cal.p6 = cal_press_b_ff[31:16];
   assign cal.p7 = cal_press_b_ff[47:32];
   assign cal.p8 = cal_press_b_ff[63:48];
   assign cal.p9 = cal_p9_ff;

   bptc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal),
      .req_ch    (req_ch),
      .push      (push),
      .push_item (push_item),
      .full      (full)
   );

   bptc_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (QITEM_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (push_item),
      .pop   (pop),
      .rdata (q_rdata),
      .full  (full),
      .avail (avail)
   );

   assign pop_item = q_rdata;

   bptc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cal     (cal),
      .q_avail (avail),
      .q_item  (pop_item),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

/* hdl/bptc_front.sv */
// bptc_front: accepts requests, computes fine temperature and centidegrees.
// Depends on bptc_pkg and bptc_req_if.
module bptc_front import bptc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  bptc_cal_type   cal,
   bptc_req_if.sink       req_ch,
   output logic           push,
   output bptc_qitem_type push_item,
   input  logic           full
);

   logic [3:0] vld_ff;
   logic       en;

   logic signed [17:0] a_s;
   logic signed [16:0] b_s;
   logic signed [33:0] prod_a_in, prod_a_ff;
   logic signed [33:0] prod_b_in, prod_b_ff;
   logic [19:0]        up1_ff, up2_ff, up3_ff, up4_ff;

   logic signed [21:0] bsh;
   logic signed [37:0] x_in, x_ff;
   logic signed [22:0] v1t_ff;

   logic signed [23:0] tfine_in, tfine3_ff, tfine4_ff;
   logic signed [26:0] t5;
   logic signed [18:0] tsh;
   logic signed [15:0] temp_in, temp_ff;

   assign en           = !(vld_ff[3] && full);
   assign req_ch.ready = en;
   assign push         = vld_ff[3] && !full;

   assign a_s       = $signed({1'b0, req_ch.raw_temperature[19:3]}) -
                      $signed({1'b0, cal.t1, 1'b0});
   assign b_s       = $signed({1'b0, req_ch.raw_temperature[19:4]}) -
                      $signed({1'b0, cal.t1});
   assign prod_a_in = a_s * cal.t2;
   assign prod_b_in = b_s * b_s;

   assign bsh  = prod_b_ff[33:12];
   assign x_in = bsh * cal.t3;

   assign tfine_in = {v1t_ff[22], v1t_ff} + x_ff[37:14];

   assign t5  = tfine3_ff * TEMP_MUL + TEMP_ROUND;
   assign tsh = t5[26:8];
   always_comb begin
      if (tsh > 19'sd32767) begin
         temp_in = 16'sh7fff;
      end else if (tsh < -19'sd32768) begin
         temp_in = 16'sh8000;
      end else begin
         temp_in = tsh[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         up1_ff    <= req_ch.raw_pressure;
         x_ff      <= x_in;
         v1t_ff    <= prod_a_ff[33:11];
         up2_ff    <= up1_ff;
         tfine3_ff <= tfine_in;
         up3_ff    <= up2_ff;
         tfine4_ff <= tfine3_ff;
         temp_ff   <= temp_in;
         up4_ff    <= up3_ff;
      end
   end

   assign push_item.raw_pressure = up4_ff;
   assign push_item.t_fine       = tfine4_ff;
   assign push_item.temp_centi   = temp_ff;

endmodule

/* hdl/bptc_fifo.sv */
// bptc_fifo: short queue between the front and back halves.
// Depends on nothing but its parameters.
module bptc_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 60
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             avail
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CDEPTH = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    cnt_ff;

   assign full  = (cnt_ff == CDEPTH);
   assign avail = (cnt_ff != '0);
   assign rdata = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CDEPTH) else $error("queue count beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count not advanced on push");

endmodule

/* hdl/bptc_div.sv */
// bptc_div: pipelined restoring divider, one quotient bit per stage.
// Depends on bptc_pkg.
module bptc_div import bptc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [63:0]    dividend,
   input  logic [30:0]    divisor,
   input  bptc_dmeta_type in_meta,
   output logic           out_valid,
   output logic [63:0]    quotient,
   output bptc_dmeta_type out_meta
);

   logic [30:0]    rem_ff  [DIV_STAGES];
   logic [63:0]    dq_ff   [DIV_STAGES];
   logic [30:0]    ub_ff   [DIV_STAGES];
   bptc_dmeta_type meta_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff;

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic [30:0]    prev_rem;
      logic [63:0]    prev_dq;
      logic [30:0]    prev_ub;
      bptc_dmeta_type prev_meta;
      logic [31:0]    trial;
      logic           ge;

      if (i == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_dq   = dividend;
         assign prev_ub   = divisor;
         assign prev_meta = in_meta;
      end else begin : g_next
         assign prev_rem  = rem_ff[i-1];
         assign prev_dq   = dq_ff[i-1];
         assign prev_ub   = ub_ff[i-1];
         assign prev_meta = meta_ff[i-1];
      end

      assign trial = {prev_rem, prev_dq[63]};
      assign ge    = trial >= {1'b0, prev_ub};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? 31'(trial - {1'b0, prev_ub}) : trial[30:0];
            dq_ff[i]   <= {prev_dq[62:0], ge};
            ub_ff[i]   <= prev_ub;
            meta_ff[i] <= prev_meta;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign quotient  = dq_ff[DIV_STAGES-1];
   assign out_meta  = meta_ff[DIV_STAGES-1];

endmodule

/* hdl/bptc_back.sv */
// bptc_back: pressure polynomial, divider and final correction, output register.
// Depends on bptc_pkg, bptc_div and bptc_rsp_if.
module bptc_back import bptc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  bptc_cal_type   cal,
   input  logic           q_avail,
   input  bptc_qitem_type q_item,
   output logic           pop,
   bptc_rsp_if.source     rsp_ch
);

   logic       en;
   logic [5:0] b_vld_ff;
   logic [3:0] p_vld_ff;

   // B1
   logic signed [24:0] v1_in;
   logic signed [49:0] sq_in, sq_ff;
   logic signed [40:0] m5_in, m5_ff, m2_in, m2_ff;
   logic [19:0]        up1_ff, up2_ff, up3_ff;
   logic signed [15:0] tc1_ff, tc2_ff, tc3_ff, tc4_ff, tc5_ff;
   // B2
   logic signed [65:0] s6, s3;
   logic [63:0]        v2a_ff, v1a_ff;
   logic signed [40:0] m5b_ff, m2b_ff;
   // B3
   logic [63:0]        v2_ff, v1b_ff;
   // B4
   logic [63:0]        w;
   logic [47:0]        pp_lo_ff, pp_hi_full;
   logic [31:0]        pp_hi_ff;
   logic [20:0]        pn;
   logic [63:0]        n0_ff;
   // B5
   logic [63:0]        prod;
   logic [30:0]        d_ff;
   logic [43:0]        nlo_ff, nhi_full;
   logic [31:0]        nhi_ff;
   // B6
   logic [63:0]        num;
   logic [63:0]        ua_ff;
   logic [30:0]        ub_ff;
   bptc_dmeta_type     dmeta_ff;
   // divider
   logic               div_vld;
   logic [63:0]        dq;
   bptc_dmeta_type     dmeta_o;
   // P1
   logic [63:0]        p_in, p1_ff, p2_ff;
   logic signed [50:0] s_in, s_ff;
   logic signed [66:0] r1_full;
   logic [63:0]        r1_ff;
   logic signed [48:0] blo_in, blo_ff;
   logic signed [47:0] bhi_full;
   logic [31:0]        bhi_ff;
   bptc_dmeta_type     pm1_ff, pm2_ff, pm3_ff;
   // P2
   logic [63:0]        s64;
   logic [63:0]        mll_ff;
   logic [63:0]        mlh_full, mhl_full;
   logic [31:0]        mlh_ff, mhl_ff;
   logic [63:0]        bsum_ff;
   // P3
   logic [63:0]        a_w;
   logic [63:0]        pf_ff;
   // out
   logic [63:0]        pfin;
   logic [23:0]        press_ff;
   logic               pvalid_ff;
   logic signed [15:0] temp_ff;

   assign en  = !p_vld_ff[3] || rsp_ch.ready;
   assign pop = en && q_avail;

   // B1
   assign v1_in = $signed({q_item.t_fine[23], q_item.t_fine}) - TFINE_OFFSET;
   assign sq_in = v1_in * v1_in;
   assign m5_in = v1_in * cal.p5;
   assign m2_in = v1_in * cal.p2;
   // B2
   assign s6 = sq_ff * cal.p6;
   assign s3 = sq_ff * cal.p3;
   // B4
   assign w          = P1_BIAS + v1b_ff;
   assign pp_hi_full = w[63:32] * cal.p1;
   assign pn         = PRESS_BASE - {1'b0, up3_ff};
   // B5
   assign prod     = {16'b0, pp_lo_ff} + {pp_hi_ff, 32'b0};
   assign nhi_full = n0_ff[63:32] * DIV_SCALE;
   // B6
   assign num = {20'b0, nlo_ff} + {nhi_ff, 32'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= sq_in;
         m5_ff    <= m5_in;
         m2_ff    <= m2_in;
         up1_ff   <= q_item.raw_pressure;
         tc1_ff   <= q_item.temp_centi;

         v2a_ff   <= s6[63:0];
         v1a_ff   <= s3[63:0];
         m5b_ff   <= m5_ff;
         m2b_ff   <= m2_ff;
         up2_ff   <= up1_ff;
         tc2_ff   <= tc1_ff;

         v2_ff    <= v2a_ff + {{6{m5b_ff[40]}}, m5b_ff, 17'b0} +
                     {{13{cal.p4[15]}}, cal.p4, 35'b0};
         v1b_ff   <= {{8{v1a_ff[63]}}, v1a_ff[63:8]} + {{11{m2b_ff[40]}}, m2b_ff, 12'b0};
         up3_ff   <= up2_ff;
         tc3_ff   <= tc2_ff;

         pp_lo_ff <= w[31:0] * cal.p1;
         pp_hi_ff <= pp_hi_full[31:0];
         n0_ff    <= {12'b0, pn, 31'b0} - v2_ff;
         tc4_ff   <= tc3_ff;

         d_ff     <= prod[63:33];
         nlo_ff   <= n0_ff[31:0] * DIV_SCALE;
         nhi_ff   <= nhi_full[31:0];
         tc5_ff   <= tc4_ff;

         ua_ff    <= num[63] ? 64'(-num) : num;
         ub_ff    <= d_ff[30] ? 31'(-d_ff) : d_ff;
         dmeta_ff <= '{temp_centi: tc5_ff, neg: num[63] ^ d_ff[30],
                       zero: (d_ff == '0)};
      end
   end

   bptc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_vld_ff[5]),
      .dividend  (ua_ff),
      .divisor   (ub_ff),
      .in_meta   (dmeta_ff),
      .out_valid (div_vld),
      .quotient  (dq),
      .out_meta  (dmeta_o)
   );

   // P1
   assign p_in     = dmeta_o.neg ? 64'(-dq) : dq;
   assign s_in     = p_in[63:13];
   assign r1_full  = cal.p9 * s_in;
   assign blo_in   = $signed({1'b0, p_in[31:0]}) * cal.p8;
   assign bhi_full = $signed(p_in[63:32]) * cal.p8;
   // P2: low 64 bits of r1 * s from 32-bit partial products
   assign s64      = {{13{s_ff[50]}}, s_ff};
   assign mlh_full = r1_ff[31:0] * s64[63:32];
   assign mhl_full = r1_ff[63:32] * s64[31:0];
   // P3
   assign a_w  = mll_ff + {32'(mlh_ff + mhl_ff), 32'b0};
   // out
   assign pfin = {{8{pf_ff[63]}}, pf_ff[63:8]} + {{44{cal.p7[15]}}, cal.p7, 4'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= p_in;
         s_ff    <= s_in;
         r1_ff   <= r1_full[63:0];
         blo_ff  <= blo_in;
         bhi_ff  <= bhi_full[31:0];
         pm1_ff  <= dmeta_o;

         mll_ff  <= r1_ff[31:0] * s64[31:0];
         mlh_ff  <= mlh_full[31:0];
         mhl_ff  <= mhl_full[31:0];
         bsum_ff <= {{15{blo_ff[48]}}, blo_ff} + {bhi_ff, 32'b0};
         p2_ff   <= p1_ff;
         pm2_ff  <= pm1_ff;

         pf_ff   <= p2_ff + {{25{a_w[63]}}, a_w[63:25]} +
                    {{19{bsum_ff[63]}}, bsum_ff[63:19]};
         pm3_ff  <= pm2_ff;

         press_ff  <= pm3_ff.zero ? 24'd0 : pfin[31:8];
         pvalid_ff <= !pm3_ff.zero;
         temp_ff   <= pm3_ff.temp_centi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= '0;
         p_vld_ff <= '0;
      end else if (en) begin
         b_vld_ff <= {b_vld_ff[4:0], pop};
         p_vld_ff <= {p_vld_ff[2:0], div_vld};
      end
   end

   assign rsp_ch.valid             = p_vld_ff[3];
   assign rsp_ch.pressure_pa       = press_ff;
   assign rsp_ch.pressure_valid    = pvalid_ff;
   assign rsp_ch.temperature_centi = temp_ff;

   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> ##0
      (!rsp_ch.pressure_valid -> rsp_ch.pressure_pa == '0) or rsp_ch.ready)
      else $error("zero divisor result carries pressure");
   a_drop_on_take: assert property (@(posedge clock) disable iff (reset)
      $fell(p_vld_ff[3]) |-> $past(rsp_ch.ready))
      else $error("result withdrawn without being taken");
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=>
      (rsp_ch.valid && $stable(press_ff) && $stable(pvalid_ff) && $stable(temp_ff)))
      else $error("response changed while stalled");

endmodule
